// File: rtl/core/bpa_pkg.sv
package bpa_pkg;

  localparam int unsigned PAGE_COUNT_DEF = 16384;
  localparam int unsigned TOP_ORDER_DEF  = 10;
  localparam int unsigned NODE_COUNT_DEF = 4;

  localparam int unsigned CNT_W  = 15;
  localparam int unsigned PAGE_W = 14;

  localparam logic [14:0] DMA_LIMIT_RST  = 15'd4096;
  localparam logic [14:0] PAGE_LIMIT_RST = 15'd16384;
  localparam logic [14:0] RESERVE_RST    = 15'd64;
  localparam logic [1:0]  DEF_NODE_RST   = 2'd0;

  typedef enum logic [1:0] {
    CFG_DMA_LIMIT  = 2'd0,
    CFG_PAGE_LIMIT = 2'd1,
    CFG_RESERVE    = 2'd2,
    CFG_DEF_NODE   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MD_ALLOC   = 2'd0,
    MD_FREE    = 2'd1,
    MD_ADD     = 2'd2,
    MD_RESERVE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_NOMEM  = 3'd1,
    ST_ORDER  = 3'd2,
    ST_DOUBLE = 3'd3,
    ST_SKIP   = 3'd4,
    ST_RANGE  = 3'd5
  } status_t;

endpackage

// File: rtl/core/buddy_page_allocator_top.sv
// Channel  | Direction | Handshake          | Word
// in       | receive   | in_valid/in_stall  | mode, page_number, block_order, req_node,
//          |           |                    | want_dma, atomic_ok
// out      | send      | out_valid/out_stall| status, result_page, dma_free, normal_free
// cfg      | receive   | cfg_we             | cfg_index, cfg_data
//
// One word at a time. A request's list pushes, list pops and link visits in a list
// removal all run on the single port of the page table. Allocate tries each node in turn.
// After reset the page table is cleared, with in_stall high.
// A new request is taken while the last result waits; the finished one then
// waits in the finish step until the output register is free (out_stall drops).
module buddy_page_allocator_top #(
  parameter int unsigned PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF,
  parameter int unsigned TOP_ORDER  = bpa_pkg::TOP_ORDER_DEF,
  parameter int unsigned NODE_COUNT = bpa_pkg::NODE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [13:0] page_number,
  input  logic [3:0]  block_order,
  input  logic [2:0]  req_node,
  input  logic        want_dma,
  input  logic        atomic_ok,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [13:0] result_page,
  output logic [14:0] dma_free,
  output logic [14:0] normal_free,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  localparam int unsigned PW = $clog2(PAGE_COUNT);
  localparam int unsigned NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int unsigned OW = $clog2(TOP_ORDER + 1);
  localparam int unsigned OC = TOP_ORDER + 1;
  localparam int unsigned AC = 2 * NODE_COUNT;
  localparam int unsigned AW = $clog2(AC);
  localparam int unsigned LC = AC * OC;
  localparam int unsigned LW = $clog2(LC);
  localparam int unsigned SW = $clog2(PAGE_COUNT + 1);
  localparam int unsigned CW = bpa_pkg::CNT_W;

  typedef struct packed {
    logic [PW-1:0] nxt;
    logic          nxt_ok;
    logic          is_free;
    logic [OW-1:0] ord;
    logic          zone;
    logic [NW-1:0] node;
  } pte_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_A_TRY, S_A_POP1, S_A_POP2, S_A_SPLIT, S_F_RD, S_ADD_RD,
    S_M_CHK, S_M_BD, S_M_NEXT, S_R_RD, S_R_AFT, S_R_SPLIT, S_R_FIN, S_PUSH_RD,
    S_PUSH_WR, S_RM_RD, S_RM_HD, S_RM_LOOP, S_RM_CMP, S_RM_CLR, S_FINISH
  } state_t;

  function automatic logic [LW-1:0] lidx(input logic z, input logic [NW-1:0] n,
                                         input logic [OW-1:0] o);
    logic [31:0] a;
    a = z ? (32'(NODE_COUNT) + 32'(n)) : 32'(n);
    return LW'(a * OC + 32'(o));
  endfunction

  function automatic logic [NW-1:0] pick_node(input logic [2:0] rn, input logic [1:0] dn);
    if (32'(rn) < NODE_COUNT) return NW'(rn);
    if (32'(dn) < NODE_COUNT) return NW'(dn);
    return '0;
  endfunction

  // page table and list head memories
  pte_t          pt_mem [PAGE_COUNT];
  logic [PW-1:0] hd_mem [LC];
  logic [PW-1:0] pt_addr, hd_wdata, hd_rdata;
  logic [LW-1:0] hd_addr;
  logic          pt_we, hd_we;
  pte_t          pt_wdata, pt_rdata, ent;

  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[pt_addr] <= pt_wdata;
    pt_rdata <= pt_mem[pt_addr];
  end

  always_ff @(posedge clk) begin
    if (hd_we) hd_mem[hd_addr] <= hd_wdata;
    hd_rdata <= hd_mem[hd_addr];
  end

  state_t state, ret;
  logic [14:0] dma_limit, page_limit, keep_back;
  logic [1:0]  default_node;
  logic [PW-1:0] clr_cnt, pg_r, bd_r, head_r, psh_pg, rm_tgt, cur, prev;
  logic [OW-1:0] ord_r, req_ord, psh_ord;
  logic [NW-1:0] node_r, att, pg_node, psh_node;
  logic          zone_r, pg_zone, psh_zone, atomic_r, cur_ok, have_prev, rm_found;
  logic [SW-1:0] steps;
  pte_t          prev_ent, cur_ent;
  logic [LC-1:0] list_ok;
  logic [AC-1:0] present;
  logic [CW-1:0] zone_cnt [2];
  bpa_pkg::status_t st_r, status_r;
  logic [13:0]   res_r, result_r;
  logic [CW-1:0] dma_out, norm_out;

  logic [AW-1:0] area_c;
  logic [LW-1:0] l_cur, l_psh;
  logic [OC-1:0] area_ok, cand, lowest;
  logic [OW-1:0] find_ord, sub_ord;
  logic          found_any, alloc_ok;
  logic [31:0]   bd_w, half_w, hi_w;
  logic [PW-1:0] push_head;

  assign ent = pt_rdata;

  always_comb begin
    area_c  = zone_r ? (AW'(NODE_COUNT) + AW'(node_r)) : AW'(node_r);
    l_cur   = lidx(zone_r, node_r, ord_r);
    l_psh   = lidx(zone_r, node_r, psh_ord);
    area_ok = list_ok[lidx(zone_r, node_r, '0) +: OC];
    for (int i = 0; i < OC; i++) cand[i] = area_ok[i] && (i >= int'(req_ord));
    lowest  = cand & (~cand + OC'(1));
    find_ord = '0;
    for (int i = 0; i < OC; i++) if (lowest[i]) find_ord = find_ord | OW'(i);
    found_any = |cand;
    alloc_ok = present[area_c] && found_any &&
               (atomic_r || (32'(zone_cnt[zone_r]) >
                             32'(keep_back) + (32'd1 << req_ord)));
    sub_ord   = ord_r - OW'(1);
    bd_w      = 32'(pg_r) ^ (32'd1 << ord_r);
    half_w    = 32'(pg_r) + (32'd1 << sub_ord);
    hi_w      = 32'(head_r) + (32'd1 << sub_ord);
    push_head = list_ok[l_psh] ? hd_rdata : '0;
  end

  // memory port control
  always_comb begin
    pt_addr  = '0;
    pt_we    = 1'b0;
    pt_wdata = '0;
    hd_addr  = '0;
    hd_we    = 1'b0;
    hd_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        pt_addr = clr_cnt;
        pt_we   = 1'b1;
      end
      S_IDLE:   pt_addr = PW'(page_number);
      S_A_TRY:  hd_addr = lidx(zone_r, node_r, find_ord);
      S_A_POP1: pt_addr = hd_rdata;
      S_A_POP2: begin
        hd_addr  = l_cur;
        hd_we    = 1'b1;
        hd_wdata = ent.nxt;
      end
      S_A_SPLIT: begin
        if (ord_r == req_ord) begin
          pt_addr       = pg_r;
          pt_we         = 1'b1;
          pt_wdata.ord  = req_ord;
          pt_wdata.zone = pg_zone;
          pt_wdata.node = pg_node;
        end
      end
      S_ADD_RD: begin
        // fresh page takes its zone and node before the merge walk
        pt_addr         = pg_r;
        pt_we           = !ent.is_free;
        pt_wdata.nxt    = ent.nxt;
        pt_wdata.nxt_ok = ent.nxt_ok;
        pt_wdata.zone   = zone_r;
        pt_wdata.node   = node_r;
      end
      S_M_CHK:   pt_addr = PW'(bd_w);
      S_R_SPLIT: pt_addr = head_r;
      S_R_FIN: begin
        pt_addr         = head_r;
        pt_we           = 1'b1;
        pt_wdata.nxt    = ent.nxt;
        pt_wdata.nxt_ok = ent.nxt_ok;
        pt_wdata.zone   = ent.zone;
        pt_wdata.node   = ent.node;
      end
      S_PUSH_RD: hd_addr = l_psh;
      S_PUSH_WR: begin
        pt_addr          = psh_pg;
        pt_we            = 1'b1;
        pt_wdata.nxt     = push_head;
        pt_wdata.nxt_ok  = list_ok[l_psh];
        pt_wdata.is_free = 1'b1;
        pt_wdata.ord     = psh_ord;
        pt_wdata.zone    = psh_zone;
        pt_wdata.node    = psh_node;
        hd_addr          = l_psh;
        hd_we            = 1'b1;
        hd_wdata         = psh_pg;
      end
      S_RM_RD:   hd_addr = l_cur;
      S_RM_LOOP: pt_addr = cur;
      S_RM_CMP: begin
        if (cur == rm_tgt) begin
          if (have_prev) begin
            pt_addr         = prev;
            pt_we           = 1'b1;
            pt_wdata        = prev_ent;
            pt_wdata.nxt    = ent.nxt;
            pt_wdata.nxt_ok = ent.nxt_ok;
          end else begin
            hd_addr  = l_cur;
            hd_we    = 1'b1;
            hd_wdata = ent.nxt;
          end
        end
      end
      S_RM_CLR: begin
        pt_addr       = cur;
        pt_we         = 1'b1;
        pt_wdata.ord  = cur_ent.ord;
        pt_wdata.zone = cur_ent.zone;
        pt_wdata.node = cur_ent.node;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_cnt        <= '0;
      list_ok        <= '0;
      present        <= '0;
      zone_cnt[0]    <= '0;
      zone_cnt[1]    <= '0;
      out_valid      <= 1'b0;
      dma_limit      <= bpa_pkg::DMA_LIMIT_RST;
      page_limit     <= bpa_pkg::PAGE_LIMIT_RST;
      keep_back      <= bpa_pkg::RESERVE_RST;
      default_node   <= bpa_pkg::DEF_NODE_RST;
    end else begin
      if (cfg_we) begin
        unique case (bpa_pkg::cfg_idx_t'(cfg_index))
          bpa_pkg::CFG_DMA_LIMIT:  dma_limit      <= cfg_data;
          bpa_pkg::CFG_PAGE_LIMIT: page_limit     <= cfg_data;
          bpa_pkg::CFG_RESERVE:    keep_back      <= cfg_data;
          bpa_pkg::CFG_DEF_NODE:   default_node   <= cfg_data[1:0];
          default: ;
        endcase
      end
      // the finish step loads the next word itself
      if (out_valid && !out_stall && state != S_FINISH) out_valid <= 1'b0;

      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + PW'(1);
          if (clr_cnt == PW'(PAGE_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            res_r    <= '0;
            pg_r     <= PW'(page_number);
            atomic_r <= atomic_ok;
            unique case (bpa_pkg::mode_t'(mode))
              bpa_pkg::MD_ALLOC: begin
                if (32'(block_order) > TOP_ORDER) begin
                  st_r  <= bpa_pkg::ST_ORDER;
                  state <= S_FINISH;
                end else begin
                  req_ord <= OW'(block_order);
                  node_r  <= pick_node(req_node, default_node);
                  zone_r  <= !want_dma;
                  att     <= '0;
                  state   <= S_A_TRY;
                end
              end
              bpa_pkg::MD_FREE: begin
                if (32'(page_number) >= PAGE_COUNT) begin
                  st_r  <= bpa_pkg::ST_RANGE;
                  state <= S_FINISH;
                end else if (32'(block_order) > TOP_ORDER) begin
                  st_r  <= bpa_pkg::ST_ORDER;
                  state <= S_FINISH;
                end else begin
                  ord_r <= OW'(block_order);
                  state <= S_F_RD;
                end
              end
              bpa_pkg::MD_ADD: begin
                if (32'(page_number) >= PAGE_COUNT) begin
                  st_r  <= bpa_pkg::ST_RANGE;
                  state <= S_FINISH;
                end else begin
                  node_r <= pick_node(req_node, default_node);
                  zone_r <= {1'b0, page_number} >= dma_limit;
                  ord_r  <= '0;
                  state  <= S_ADD_RD;
                end
              end
              bpa_pkg::MD_RESERVE: begin
                if (32'(page_number) >= PAGE_COUNT || {1'b0, page_number} >= page_limit) begin
                  st_r  <= bpa_pkg::ST_RANGE;
                  state <= S_FINISH;
                end else begin
                  state <= S_R_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_A_TRY: begin
          if (alloc_ok) begin
            ord_r <= find_ord;
            state <= S_A_POP1;
          end else if (att == NW'(NODE_COUNT - 1)) begin
            st_r  <= bpa_pkg::ST_NOMEM;
            state <= S_FINISH;
          end else begin
            att    <= att + NW'(1);
            node_r <= (node_r == NW'(NODE_COUNT - 1)) ? '0 : node_r + NW'(1);
          end
        end
        S_A_POP1: begin
          pg_r  <= hd_rdata;
          state <= S_A_POP2;
        end
        S_A_POP2: begin
          list_ok[l_cur]   <= ent.nxt_ok;
          zone_cnt[zone_r] <= zone_cnt[zone_r] - CW'(32'd1 << ord_r);
          pg_zone          <= ent.zone;
          pg_node          <= ent.node;
          state            <= S_A_SPLIT;
        end
        S_A_SPLIT: begin
          if (ord_r != req_ord) begin
            ord_r <= sub_ord;
            // high half beyond the table is dropped
            if (half_w < PAGE_COUNT) begin
              psh_pg   <= PW'(half_w);
              psh_ord  <= sub_ord;
              psh_zone <= pg_zone;
              psh_node <= node_r;
              ret      <= S_A_SPLIT;
              state    <= S_PUSH_RD;
            end
          end else begin
            res_r <= 14'(pg_r);
            st_r  <= bpa_pkg::ST_OK;
            state <= S_FINISH;
          end
        end
        S_F_RD: begin
          if (ent.is_free) begin
            st_r  <= bpa_pkg::ST_DOUBLE;
            state <= S_FINISH;
          end else begin
            zone_r <= ent.zone;
            node_r <= ent.node;
            state  <= S_M_CHK;
          end
        end
        S_ADD_RD: begin
          if (ent.is_free) begin
            st_r  <= bpa_pkg::ST_DOUBLE;
            state <= S_FINISH;
          end else begin
            present[area_c] <= 1'b1;
            state           <= S_M_CHK;
          end
        end
        S_M_CHK: begin
          if (32'(ord_r) < TOP_ORDER && bd_w < 32'(page_limit) && bd_w < PAGE_COUNT) begin
            bd_r  <= PW'(bd_w);
            state <= S_M_BD;
          end else begin
            psh_pg   <= pg_r;
            psh_ord  <= ord_r;
            psh_zone <= zone_r;
            psh_node <= node_r;
            st_r     <= bpa_pkg::ST_OK;
            ret      <= S_FINISH;
            state    <= S_PUSH_RD;
          end
        end
        S_M_BD: begin
          if (ent.is_free && ent.ord == ord_r && ent.zone == zone_r && ent.node == node_r) begin
            rm_tgt <= bd_r;
            ret    <= S_M_NEXT;
            state  <= S_RM_RD;
          end else begin
            psh_pg   <= pg_r;
            psh_ord  <= ord_r;
            psh_zone <= zone_r;
            psh_node <= node_r;
            st_r     <= bpa_pkg::ST_OK;
            ret      <= S_FINISH;
            state    <= S_PUSH_RD;
          end
        end
        S_M_NEXT: begin
          // merge goes on whether or not the buddy was found in its list
          if (bd_r < pg_r) pg_r <= bd_r;
          ord_r <= ord_r + OW'(1);
          state <= S_M_CHK;
        end
        S_R_RD: begin
          if (!ent.is_free || 32'(ent.ord) > TOP_ORDER) begin
            st_r  <= bpa_pkg::ST_SKIP;
            state <= S_FINISH;
          end else begin
            ord_r  <= ent.ord;
            head_r <= pg_r & ~PW'((32'd1 << ent.ord) - 32'd1);
            rm_tgt <= pg_r & ~PW'((32'd1 << ent.ord) - 32'd1);
            zone_r <= ent.zone;
            node_r <= ent.node;
            ret    <= S_R_AFT;
            state  <= S_RM_RD;
          end
        end
        S_R_AFT: begin
          if (!rm_found) begin
            st_r  <= bpa_pkg::ST_SKIP;
            state <= S_FINISH;
          end else begin
            state <= S_R_SPLIT;
          end
        end
        S_R_SPLIT: begin
          if (ord_r != '0) begin
            ord_r    <= sub_ord;
            psh_ord  <= sub_ord;
            psh_zone <= zone_r;
            psh_node <= node_r;
            if (32'(pg_r) >= hi_w) begin
              psh_pg <= head_r;
              head_r <= PW'(hi_w);
              ret    <= S_R_SPLIT;
              state  <= S_PUSH_RD;
            end else if (hi_w < PAGE_COUNT) begin
              psh_pg <= PW'(hi_w);
              ret    <= S_R_SPLIT;
              state  <= S_PUSH_RD;
            end
          end else begin
            state <= S_R_FIN;
          end
        end
        S_R_FIN: begin
          st_r  <= bpa_pkg::ST_OK;
          state <= S_FINISH;
        end
        S_PUSH_RD: state <= S_PUSH_WR;
        S_PUSH_WR: begin
          list_ok[l_psh]   <= 1'b1;
          zone_cnt[zone_r] <= zone_cnt[zone_r] + CW'(32'd1 << psh_ord);
          state            <= ret;
        end
        S_RM_RD: state <= S_RM_HD;
        S_RM_HD: begin
          cur       <= list_ok[l_cur] ? hd_rdata : '0;
          cur_ok    <= list_ok[l_cur];
          have_prev <= 1'b0;
          steps     <= '0;
          state     <= S_RM_LOOP;
        end
        S_RM_LOOP: begin
          // walk is bounded so a looped list cannot hang the block
          if (!cur_ok || steps == SW'(PAGE_COUNT)) begin
            rm_found <= 1'b0;
            state    <= ret;
          end else begin
            state <= S_RM_CMP;
          end
        end
        S_RM_CMP: begin
          if (cur == rm_tgt) begin
            if (!have_prev) list_ok[l_cur] <= ent.nxt_ok;
            cur_ent <= ent;
            state   <= S_RM_CLR;
          end else begin
            prev      <= cur;
            prev_ent  <= ent;
            have_prev <= 1'b1;
            cur       <= ent.nxt;
            cur_ok    <= ent.nxt_ok;
            steps     <= steps + SW'(1);
            state     <= S_RM_LOOP;
          end
        end
        S_RM_CLR: begin
          zone_cnt[zone_r] <= zone_cnt[zone_r] - CW'(32'd1 << ord_r);
          rm_found         <= 1'b1;
          state            <= ret;
        end
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            status_r  <= st_r;
            result_r  <= res_r;
            dma_out   <= zone_cnt[0];
            norm_out  <= zone_cnt[1];
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall    = (state != S_IDLE);
  assign status      = status_r;
  assign result_page = result_r;
  assign dma_free    = dma_out;
  assign normal_free = norm_out;

endmodule

// File: rtl/core/bpa_checker.sv
module bpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [13:0] result_page
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(result_page))
    else $error("stalled result word changed");

  // only a good allocation carries a page
  a_page_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != bpa_pkg::ST_OK |-> result_page == '0)
    else $error("failed request returned a page");

  // one request in flight: busy right after a word is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while busy");

  // a result only comes out of a busy block
  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a request");

endmodule

bind buddy_page_allocator_top bpa_checker u_bpa_checker (.*);
